@@ rtl/glob_wildcard_matcher_top_assert.svh @@
// Assertion macros for the glob wildcard matcher.
// Used by glob_wildcard_matcher_top; relies on clk_i and rst_ni in scope.
`ifndef GLOB_WILDCARD_MATCHER_TOP_ASSERT_SVH
`define GLOB_WILDCARD_MATCHER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GWM_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("glob matcher check failed");

// The consequent must hold in the cycle after the antecedent.
`define GWM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("glob matcher check failed");

`endif

@@ rtl/gwm_pkg.sv @@
// Shared types and constants of the glob wildcard matcher.
// Used by gwm_cell and glob_wildcard_matcher_top; no dependencies.
package gwm_pkg;

  localparam int unsigned PATTERN_LEN_DEF = 64;
  localparam int unsigned BYTE_W          = 8;
  localparam logic [7:0]  STAR_BYTE       = 8'h2A;
  localparam logic [7:0]  WILDCARD_RESET  = 8'h3F;

  localparam int unsigned APB_ADDR_W       = 3;
  localparam int unsigned APB_DATA_W       = 32;
  localparam logic [0:0]  REG_IDX_WILDCARD = 1'b0;

  typedef enum logic [1:0] {
    KIND_CLEAR   = 2'd0,
    KIND_PATTERN = 2'd1,
    KIND_NAME    = 2'd2,
    KIND_END     = 2'd3
  } kind_e;

  typedef struct packed {
    logic       restart;
    logic       advance;
    logic [7:0] byte_val;
    logic [7:0] wild;
  } cell_ctrl_t;

endpackage

@@ rtl/glob_wildcard_matcher_top.sv @@
// Top level of the glob wildcard matcher: stream ports, APB register, cell row.
// Depends on gwm_pkg, gwm_cell, gwm_closure and glob_wildcard_matcher_top_assert.svh.
//
// Channel   Direction  Contents
// s_axis    in         tuser kind, tdata pattern or name byte
// m_axis    out        tdata matched and pattern overflow flags
// apb       in/out     wildcard byte register at address 0
//
// A new item may follow every accepted item directly, unless the input is stalled.
// A result is registered into the output buffer on its end-of-name transfer.
// A two-entry output buffer lets input continue while one result waits.
// The input stalls only when both output entries are full.
// Reset sets length and overflow to zero and the wildcard byte to question mark.
module glob_wildcard_matcher_top #(
  parameter int unsigned PATTERN_LEN = gwm_pkg::PATTERN_LEN_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [7:0] byte_value
  input  logic [1:0]                       s_axis_tuser,  // [1:0] kind
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [7:0]                       m_axis_tdata,  // [0] matched, [1] pattern_overflow
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [gwm_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [gwm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [gwm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  localparam int unsigned LEN_W = $clog2(PATTERN_LEN + 1);

  gwm_pkg::kind_e      kind;
  gwm_pkg::cell_ctrl_t ctrl;
  logic                acc;
  logic [7:0]          wild_q;
  logic [LEN_W-1:0]    len_q, len_d;
  logic                ovf_q, ovf_d;
  logic                last_raw_q, last_raw_d;

  logic [PATTERN_LEN-1:0] wr, used, fwd, star;
  logic [PATTERN_LEN:0]   raw, prop, closed;

  logic       out_v_q, sk_v_q;
  logic [1:0] out_q, sk_q;
  logic [1:0] res;
  logic       push, pop;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == gwm_pkg::REG_IDX_WILDCARD) ?
                  {{(gwm_pkg::APB_DATA_W-8){1'b0}}, wild_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wild_q <= gwm_pkg::WILDCARD_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == gwm_pkg::REG_IDX_WILDCARD) begin
      wild_q <= pwdata[7:0];
    end
  end

  // Input decode.
  assign s_axis_tready = !sk_v_q;
  assign acc           = s_axis_tvalid && s_axis_tready;
  assign kind          = gwm_pkg::kind_e'(s_axis_tuser);

  always_comb begin
    ctrl.restart  = 1'b0;
    ctrl.advance  = 1'b0;
    ctrl.byte_val = s_axis_tdata;
    ctrl.wild     = wild_q;
    len_d         = len_q;
    ovf_d         = ovf_q;
    if (acc) begin
      case (kind)
        gwm_pkg::KIND_CLEAR: begin
          ctrl.restart = 1'b1;
          len_d        = '0;
          ovf_d        = 1'b0;
        end
        gwm_pkg::KIND_PATTERN: begin
          ctrl.restart = 1'b1;
          if (len_q < LEN_W'(PATTERN_LEN)) begin
            len_d = len_q + LEN_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        gwm_pkg::KIND_NAME: begin
          ctrl.advance = 1'b1;
        end
        gwm_pkg::KIND_END: begin
          ctrl.restart = 1'b1;
        end
        default: begin
          ctrl.restart = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      ovf_q      <= 1'b0;
      last_raw_q <= 1'b0;
    end else begin
      len_q      <= len_d;
      ovf_q      <= ovf_d;
      last_raw_q <= last_raw_d;
    end
  end

  // Cell row.
  for (genvar i = 0; i < PATTERN_LEN; i++) begin : g_cell
    logic fwd_in;

    assign used[i] = (len_q > LEN_W'(i));
    assign wr[i]   = acc && (kind == gwm_pkg::KIND_PATTERN) && (len_q == LEN_W'(i));

    if (i == 0) begin : g_head
      assign fwd_in = 1'b0;
    end else begin : g_body
      assign fwd_in = fwd[i-1];
    end

    gwm_cell #(
      .IS_FIRST (i == 0)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .wr_i     (wr[i]),
      .used_i   (used[i]),
      .closed_i (closed[i]),
      .fwd_i    (fwd_in),
      .fwd_o    (fwd[i]),
      .star_o   (star[i]),
      .raw_o    (raw[i])
    );
  end

  always_comb begin
    last_raw_d = last_raw_q;
    if (ctrl.restart) begin
      last_raw_d = 1'b0;
    end else if (ctrl.advance) begin
      last_raw_d = fwd[PATTERN_LEN-1];
    end
  end

  assign raw[PATTERN_LEN] = last_raw_q;
  assign prop             = {star, 1'b0};

  gwm_closure #(
    .PATTERN_LEN (PATTERN_LEN)
  ) u_closure (
    .raw_i    (raw),
    .prop_i   (prop),
    .closed_o (closed)
  );

  // Result buffer.
  assign res  = {ovf_q, closed[len_q] && !ovf_q};
  assign push = acc && (kind == gwm_pkg::KIND_END);
  assign pop  = out_v_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      sk_v_q  <= 1'b0;
    end else if (sk_v_q) begin
      if (pop) begin
        sk_v_q <= 1'b0;
      end
    end else if (push && out_v_q && !pop) begin
      sk_v_q <= 1'b1;
    end else if (push) begin
      out_v_q <= 1'b1;
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_v_q) begin
      if (pop) begin
        out_q <= sk_q;
      end
    end else if (push && out_v_q && !pop) begin
      sk_q <= res;
    end else if (push) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {6'b0, out_q};

`include "glob_wildcard_matcher_top_assert.svh"

  `GWM_ASSERT_SAME(a_skid_behind_out, sk_v_q, out_v_q)
  `GWM_ASSERT_SAME(a_ovf_full, ovf_q, len_q == LEN_W'(PATTERN_LEN))
  `GWM_ASSERT_NEXT(a_clear_len, acc && kind == gwm_pkg::KIND_CLEAR, len_q == '0 && !ovf_q)
  `GWM_ASSERT_NEXT(a_restart_set, ctrl.restart, raw == {{PATTERN_LEN{1'b0}}, 1'b1})

endmodule

@@ rtl/gwm_cell.sv @@
// One pattern position of the matcher: stores its pattern byte and its raw active bit.
// Depends on gwm_pkg.
module gwm_cell #(
  parameter bit IS_FIRST = 1'b0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gwm_pkg::cell_ctrl_t ctrl_i,
  input  logic                wr_i,
  input  logic                used_i,
  input  logic                closed_i,
  input  logic                fwd_i,
  output logic                fwd_o,
  output logic                star_o,
  output logic                raw_o
);

  logic [7:0] pat_q;
  logic       raw_q, raw_d;
  logic       is_star, is_match;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      pat_q <= ctrl_i.byte_val;
    end
  end

  assign is_star  = (pat_q == gwm_pkg::STAR_BYTE);
  assign is_match = (pat_q == ctrl_i.byte_val) || (pat_q == ctrl_i.wild);

  assign star_o = used_i && is_star;
  assign fwd_o  = used_i && closed_i && !is_star && is_match;

  always_comb begin
    raw_d = raw_q;
    if (ctrl_i.restart) begin
      raw_d = IS_FIRST;
    end else if (ctrl_i.advance) begin
      raw_d = (used_i && closed_i && is_star) || fwd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q <= IS_FIRST;
    end else begin
      raw_q <= raw_d;
    end
  end

  assign raw_o = raw_q;

endmodule

@@ rtl/gwm_closure.sv @@
// Closes the raw position set over star positions with one carry chain.
// No dependencies; sized by the pattern length parameter.
module gwm_closure #(
  parameter int unsigned PATTERN_LEN = 64
) (
  input  logic [PATTERN_LEN:0] raw_i,
  input  logic [PATTERN_LEN:0] prop_i,
  output logic [PATTERN_LEN:0] closed_o
);

  localparam int unsigned N = PATTERN_LEN + 1;

  logic [N-1:0] run;
  logic [N-1:0] sum;
  logic [N-1:0] carry;

  // A set bit travels upward through every position whose left neighbor is a star.
  assign run      = prop_i | raw_i;
  assign sum      = run + raw_i;
  assign carry    = sum ^ run ^ raw_i;
  assign closed_o = raw_i | (carry & prop_i);

endmodule
